### src/kth_smallest_select_macros.svh
// ----------------------------------------------------------------------------
// kth_smallest_select assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef KTH_SMALLEST_SELECT_MACROS_SVH
`define KTH_SMALLEST_SELECT_MACROS_SVH

// check next-cycle implication outside reset
`define KSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kss port check failed");

// check same-cycle implication outside reset
`define KSS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kss port check failed");

// check next-cycle implication, reset included
`define KSS_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("kss port check failed");

`endif

### src/kss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_pkg
// Sizes, constants and control bundles shared by the rank select block.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int DATA_W    = 32;
    localparam int RANK_W    = 11;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int CMP_W     = (RANK_W > CNT_W) ? RANK_W : CNT_W;

    localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] rank;
    } sel_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              done;
        logic [DATA_W-1:0] value;
    } sel_rsp_t;

endpackage

### src/kss_bit_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_bit_select
// Radix select: one scan of the store per key bit, MSB first, with a single
// compare-and-count unit deciding each bit of the k-th smallest order key.
// ----------------------------------------------------------------------------
module kss_bit_select
    import kss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  sel_req_t          req,
    input  logic [DATA_W-1:0] rd_data,
    output sel_rsp_t          rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_DONE
    } state_t;

    state_t            state_reg,  state_next;
    logic [ADDR_W-1:0] idx_reg,    idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  rank_reg,   rank_next;
    logic [CNT_W-1:0]  zeros_reg,  zeros_next;
    logic [DATA_W-1:0] prefix_reg, prefix_next;
    logic [DATA_W-1:0] mask_reg,   mask_next;
    logic [DATA_W-1:0] bit_reg,    bit_next;

    logic [DATA_W-1:0] key;
    logic              hit;

    assign key = rd_data ^ SIGN_FLIP;
    assign hit = ((key & mask_reg) == prefix_reg) && ((key & bit_reg) == '0);

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        rd_vld_next = 1'b0;
        count_next  = count_reg;
        rank_next   = rank_reg;
        zeros_next  = zeros_reg;
        prefix_next = prefix_reg;
        mask_next   = mask_reg;
        bit_next    = bit_reg;

        if (rd_vld_reg && hit) begin
            zeros_next = zeros_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    count_next  = req.count;
                    rank_next   = req.rank;
                    prefix_next = '0;
                    mask_next   = '0;
                    bit_next    = SIGN_FLIP;
                    zeros_next  = '0;
                    idx_next    = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_vld_next = 1'b1;
                idx_next    = idx_reg + ADDR_W'(1);
                if (CNT_W'(idx_reg) + CNT_W'(1) == count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (rank_reg > zeros_reg) begin
                    prefix_next = prefix_reg | bit_reg;
                    rank_next   = rank_reg - zeros_reg;
                end
                mask_next  = mask_reg | bit_reg;
                bit_next   = bit_reg >> 1;
                zeros_next = '0;
                idx_next   = '0;
                state_next = bit_reg[0] ? ST_DONE : ST_SCAN;
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
        end
        idx_reg    <= idx_next;
        count_reg  <= count_next;
        rank_reg   <= rank_next;
        zeros_reg  <= zeros_next;
        prefix_reg <= prefix_next;
        mask_reg   <= mask_next;
        bit_reg    <= bit_next;
    end

    assign rsp.rd_addr = idx_reg;
    assign rsp.done    = (state_reg == ST_DONE);
    assign rsp.value   = prefix_reg ^ SIGN_FLIP;

endmodule

### src/kth_smallest_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_smallest_select
// Loads signed values into a store and reports the k-th smallest after the
// beat marked last.
// ----------------------------------------------------------------------------
// Loading takes one beat per cycle, and a finished result may wait on the
// master side while the next set loads. A last beat starts selection: the
// k-th smallest is found one key bit at a time, MSB first, each bit costing
// one scan of the store through its single read port; s_tready is low
// throughout selection and until the result is placed on the master side.
// A bad rank (zero or above the count) returns at once with the error flag.
// Beats beyond the store capacity are dropped and flagged in the result.
// ----------------------------------------------------------------------------
module kth_smallest_select
    import kss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [RANK_W-1:0] cfg_data,     // rank_wanted
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,      // value
    input  logic              s_tlast,      // last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,      // selected_value
    output logic [1:0]        m_tuser       // [0] rank_error, [1] overflowed
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SELECT,
        S_EMIT
    } state_t;

    state_t            state_reg,    state_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic              ovf_reg,      ovf_next;
    logic [RANK_W-1:0] rank_reg,     rank_next;
    logic [DATA_W-1:0] res_val_reg,  res_val_next;
    logic              res_err_reg,  res_err_next;
    logic              res_ovf_reg,  res_ovf_next;
    logic              m_valid_reg,  m_valid_next;
    logic [DATA_W-1:0] m_data_reg,   m_data_next;
    logic [1:0]        m_user_reg,   m_user_next;

    logic [DATA_W-1:0] store [MAX_ITEMS];
    logic [DATA_W-1:0] rd_data_reg;

    sel_req_t          req;
    sel_rsp_t          rsp;
    logic              accept;
    logic              fits;
    logic [CNT_W-1:0]  cnt_after;
    logic              bad_rank;

    assign accept    = s_tvalid && s_tready;
    assign fits      = (count_reg < CNT_W'(MAX_ITEMS));
    assign cnt_after = count_reg + CNT_W'(fits);
    assign bad_rank  = (rank_reg == '0) || (CMP_W'(rank_reg) > CMP_W'(cnt_after));

    assign req.count = cnt_after;
    assign req.rank  = CNT_W'(rank_reg);
    assign req.start = accept && s_tlast && !bad_rank;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        rank_next    = rank_reg;
        res_val_next = res_val_reg;
        res_err_next = res_err_reg;
        res_ovf_next = res_ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (cfg_valid) begin
            rank_next = cfg_data;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD: begin
                if (accept) begin
                    if (s_tlast) begin
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        res_ovf_next = ovf_reg || !fits;
                        res_err_next = bad_rank;
                        res_val_next = '0;
                        state_next   = bad_rank ? S_EMIT : S_SELECT;
                    end else begin
                        count_next = cnt_after;
                        ovf_next   = ovf_reg || !fits;
                    end
                end
            end
            S_SELECT: begin
                if (rsp.done) begin
                    res_val_next = rsp.value;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_val_reg;
                    m_user_next  = {res_ovf_reg, res_err_reg};
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            rank_reg    <= RANK_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            rank_reg    <= rank_next;
            m_valid_reg <= m_valid_next;
        end
        res_val_reg <= res_val_next;
        res_err_reg <= res_err_next;
        res_ovf_reg <= res_ovf_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    always_ff @(posedge aclk) begin
        if (accept && fits) begin
            store[count_reg[ADDR_W-1:0]] <= s_tdata;
        end
        rd_data_reg <= store[rsp.rd_addr];
    end

    kss_bit_select u_select (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rd_data_reg),
        .rsp     (rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_LOAD);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

endmodule

### src/kss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_checker
// Port-level checks on the rank select block, bound to its top level.
// ----------------------------------------------------------------------------
`include "kth_smallest_select_macros.svh"

module kss_checker
    import kss_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [1:0]        m_tuser
);

    `KSS_ASSERT_NEXT_RST(a_idle_after_reset, !aresetn, !m_tvalid)
    `KSS_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
    `KSS_ASSERT_NOW(a_error_zero, m_tvalid && m_tuser[0], m_tdata == '0)
    `KSS_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind kth_smallest_select kss_checker u_kss_checker (.*);
